[rtl/cmf_pkg.sv]
// Shared types, constants and the CRC helper for the CRC-16 message framer.
package cmf_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 16;
    localparam int unsigned IDX_W  = 2;
    localparam int unsigned CFG_W  = 16;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h1021;
    localparam logic [CRC_W-1:0]  CRC_INIT  = 16'h0000;

    localparam logic [BYTE_W-1:0] MSG_TYPE_FIRST_RST  = 8'h00;
    localparam logic [BYTE_W-1:0] MSG_TYPE_SECOND_RST = 8'h01;
    localparam logic [CFG_W-1:0]  SENDER_ID_RST       = 16'h2222;
    localparam logic [BYTE_W-1:0] PAYLOAD_LENGTH_RST  = 8'd13;

    typedef enum logic [IDX_W-1:0] {
        REG_MSG_TYPE_FIRST  = 2'd0,
        REG_MSG_TYPE_SECOND = 2'd1,
        REG_SENDER_ID       = 2'd2,
        REG_PAYLOAD_LENGTH  = 2'd3
    } t_reg_idx;

    // back-end sequencer phases
    typedef enum logic [3:0] {
        PH_NEXT,
        PH_TYPE1,
        PH_TYPE2,
        PH_SEND_HI,
        PH_SEND_LO,
        PH_LEN,
        PH_BODY,
        PH_CRC_LO,
        PH_CRC_HI
    } t_phase;

    // classified payload word handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
        logic [BYTE_W-1:0] len;
    } t_q_item;

    typedef struct packed {
        logic [BYTE_W-1:0] msg_type_first;
        logic [BYTE_W-1:0] msg_type_second;
        logic [CFG_W-1:0]  sender_id;
    } t_hdr_cfg;

    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/cmf_front.sv]
// Front end: accepts payload words and marks the first and last of each frame.
module cmf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [cmf_pkg::BYTE_W-1:0]    i_payload_byte,
    input  logic [cmf_pkg::BYTE_W-1:0]    i_payload_length,
    input  logic                          i_q_full,
    output logic                          o_stall,
    output logic                          o_push,
    output cmf_pkg::t_q_item              o_item
);

    logic                       r_in_frame;
    logic                       n_in_frame;
    logic [cmf_pkg::BYTE_W-1:0] r_taken;
    logic [cmf_pkg::BYTE_W-1:0] n_taken;
    logic [cmf_pkg::BYTE_W-1:0] w_len;
    logic [cmf_pkg::BYTE_W-1:0] w_taken_next;
    logic                       w_last;

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // a zero length still carries one payload word
    assign w_len = (i_payload_length == '0) ? cmf_pkg::BYTE_W'(1) : i_payload_length;

    always_comb begin
        if (!r_in_frame) begin
            w_taken_next = cmf_pkg::BYTE_W'(1);
        end else if (r_taken == '1) begin
            w_taken_next = r_taken;
        end else begin
            w_taken_next = r_taken + cmf_pkg::BYTE_W'(1);
        end
        w_last = (w_taken_next >= w_len);

        o_item.data  = i_payload_byte;
        o_item.first = !r_in_frame;
        o_item.last  = w_last;
        o_item.len   = w_len;

        n_in_frame = r_in_frame;
        n_taken    = r_taken;
        if (o_push) begin
            n_in_frame = !w_last;
            n_taken    = w_last ? '0 : w_taken_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_taken    <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_taken    <= n_taken;
        end
    end

endmodule

[rtl/cmf_queue.sv]
// Short FIFO of classified words between front and back.
module cmf_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cmf_pkg::t_q_item i_item,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_head_valid,
    output cmf_pkg::t_q_item o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmf_pkg::t_q_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_do_push    = i_push && !o_full;
    assign w_do_pop     = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/cmf_back.sv]
// Back end: emits header, payload and CRC words into the output register.
module cmf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_head_valid,
    input  cmf_pkg::t_q_item           i_head,
    input  cmf_pkg::t_hdr_cfg          i_hdr,
    input  logic                       i_stall,
    output logic                       o_pop,
    output logic                       o_valid,
    output logic [cmf_pkg::BYTE_W-1:0] o_frame_byte,
    output logic                       o_frame_end
);

    cmf_pkg::t_phase            r_phase;
    cmf_pkg::t_phase            n_phase;
    logic [cmf_pkg::CRC_W-1:0]  r_crc;
    logic [cmf_pkg::CRC_W-1:0]  n_crc;
    logic                       r_o_valid;
    logic                       n_o_valid;
    logic [cmf_pkg::BYTE_W-1:0] r_o_byte;
    logic [cmf_pkg::BYTE_W-1:0] n_o_byte;
    logic                       r_o_end;
    logic                       n_o_end;

    logic                       w_adv;
    logic                       w_emit;
    logic                       w_hashed;
    logic                       w_end;
    logic [cmf_pkg::BYTE_W-1:0] w_byte;

    assign w_adv = !r_o_valid || !i_stall;

    always_comb begin
        n_phase  = r_phase;
        n_crc    = r_crc;
        n_o_valid = r_o_valid;
        n_o_byte = r_o_byte;
        n_o_end  = r_o_end;
        o_pop    = 1'b0;
        w_emit   = 1'b0;
        w_hashed = 1'b1;
        w_end    = 1'b0;
        w_byte   = i_head.data;

        if (w_adv) begin
            n_o_valid = 1'b0;
            case (r_phase)
                cmf_pkg::PH_NEXT: begin
                    if (i_head_valid) begin
                        w_emit = 1'b1;
                        if (i_head.first) begin
                            w_byte   = cmf_pkg::SYNC_BYTE;
                            w_hashed = 1'b0;
                            n_phase  = cmf_pkg::PH_TYPE1;
                        end else begin
                            o_pop   = 1'b1;
                            n_phase = i_head.last ? cmf_pkg::PH_CRC_LO : cmf_pkg::PH_NEXT;
                        end
                    end
                end
                cmf_pkg::PH_TYPE1: begin
                    w_emit  = 1'b1;
                    w_byte  = i_hdr.msg_type_first;
                    n_phase = cmf_pkg::PH_TYPE2;
                end
                cmf_pkg::PH_TYPE2: begin
                    w_emit  = 1'b1;
                    w_byte  = i_hdr.msg_type_second;
                    n_phase = cmf_pkg::PH_SEND_HI;
                end
                cmf_pkg::PH_SEND_HI: begin
                    w_emit  = 1'b1;
                    w_byte  = i_hdr.sender_id[15:8];
                    n_phase = cmf_pkg::PH_SEND_LO;
                end
                cmf_pkg::PH_SEND_LO: begin
                    w_emit  = 1'b1;
                    w_byte  = i_hdr.sender_id[7:0];
                    n_phase = cmf_pkg::PH_LEN;
                end
                cmf_pkg::PH_LEN: begin
                    w_emit  = 1'b1;
                    w_byte  = i_head.len;
                    n_phase = cmf_pkg::PH_BODY;
                end
                cmf_pkg::PH_BODY: begin
                    // head is still the frame's first word
                    w_emit  = 1'b1;
                    o_pop   = 1'b1;
                    n_phase = i_head.last ? cmf_pkg::PH_CRC_LO : cmf_pkg::PH_NEXT;
                end
                cmf_pkg::PH_CRC_LO: begin
                    w_emit   = 1'b1;
                    w_hashed = 1'b0;
                    w_byte   = r_crc[7:0];
                    n_phase  = cmf_pkg::PH_CRC_HI;
                end
                cmf_pkg::PH_CRC_HI: begin
                    w_emit   = 1'b1;
                    w_hashed = 1'b0;
                    w_end    = 1'b1;
                    w_byte   = r_crc[15:8];
                    n_phase  = cmf_pkg::PH_NEXT;
                end
                default: begin
                    n_phase = cmf_pkg::PH_NEXT;
                end
            endcase

            if (w_emit) begin
                n_o_valid = 1'b1;
                n_o_byte  = w_byte;
                n_o_end   = w_end;
                if (w_hashed) begin
                    n_crc = cmf_pkg::crc_feed(r_crc, w_byte);
                end else if (w_end || r_phase == cmf_pkg::PH_NEXT) begin
                    n_crc = cmf_pkg::CRC_INIT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= cmf_pkg::PH_NEXT;
            r_crc     <= cmf_pkg::CRC_INIT;
            r_o_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_crc     <= n_crc;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_byte <= n_o_byte;
        r_o_end  <= n_o_end;
    end

    assign o_valid      = r_o_valid;
    assign o_frame_byte = r_o_byte;
    assign o_frame_end  = r_o_end;

endmodule

[rtl/crc16_message_framer_top.sv]
// Top level of the CRC-16 message framer: config registers, front, queue and back.
//
// Payload words come in on i_valid/o_stall/i_payload_byte, framed words leave on
// o_valid/i_stall/o_frame_byte/o_frame_end. A word moves when valid is high and
// stall is low. The first payload word of a frame brings out a six-word header
// (sync 0x55, two type words, sender high/low, length) ahead of it; after the last
// payload word the CRC-16 (poly 0x1021, init 0) follows low word first, and
// o_frame_end marks the second CRC word.
// An accepted word goes through the queue to the output register. Mid-frame one
// word per cycle passes while the receiver does not stall; a frame of N payload
// words gives N + 8 output words. The input stalls only while the queue
// (QUEUE_DEPTH words) is full, e.g. during header and CRC words. When the receiver
// stalls, the output word holds and the queue keeps filling. Reset clears frame
// state, the CRC and the queue and loads the register defaults. Config writes
// (i_cfg_wr_en/i_cfg_index/i_cfg_wr_data) take effect at the next clock edge; the
// user must make them while no frame word is pending; the block does not enforce it.
module crc16_message_framer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [cmf_pkg::BYTE_W-1:0] i_payload_byte,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [cmf_pkg::BYTE_W-1:0] o_frame_byte,
    output logic                       o_frame_end,
    input  logic                       i_cfg_wr_en,
    input  logic [cmf_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [cmf_pkg::CFG_W-1:0]  i_cfg_wr_data
);

    logic [cmf_pkg::BYTE_W-1:0] r_msg_type_first;
    logic [cmf_pkg::BYTE_W-1:0] r_msg_type_second;
    logic [cmf_pkg::CFG_W-1:0]  r_sender_id;
    logic [cmf_pkg::BYTE_W-1:0] r_payload_length;

    cmf_pkg::t_hdr_cfg w_hdr;
    cmf_pkg::t_q_item  w_push_item;
    cmf_pkg::t_q_item  w_head;
    logic              w_push;
    logic              w_pop;
    logic              w_q_full;
    logic              w_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_type_first  <= cmf_pkg::MSG_TYPE_FIRST_RST;
            r_msg_type_second <= cmf_pkg::MSG_TYPE_SECOND_RST;
            r_sender_id       <= cmf_pkg::SENDER_ID_RST;
            r_payload_length  <= cmf_pkg::PAYLOAD_LENGTH_RST;
        end else if (i_cfg_wr_en) begin
            case (cmf_pkg::t_reg_idx'(i_cfg_index))
                cmf_pkg::REG_MSG_TYPE_FIRST:  r_msg_type_first  <= i_cfg_wr_data[7:0];
                cmf_pkg::REG_MSG_TYPE_SECOND: r_msg_type_second <= i_cfg_wr_data[7:0];
                cmf_pkg::REG_SENDER_ID:       r_sender_id       <= i_cfg_wr_data;
                cmf_pkg::REG_PAYLOAD_LENGTH:  r_payload_length  <= i_cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign w_hdr.msg_type_first  = r_msg_type_first;
    assign w_hdr.msg_type_second = r_msg_type_second;
    assign w_hdr.sender_id       = r_sender_id;

    cmf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_payload_byte   (i_payload_byte),
        .i_payload_length (r_payload_length),
        .i_q_full         (w_q_full),
        .o_stall          (o_stall),
        .o_push           (w_push),
        .o_item           (w_push_item)
    );

    cmf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_item       (w_push_item),
        .i_pop        (w_pop),
        .o_full       (w_q_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    cmf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .i_hdr        (w_hdr),
        .i_stall      (i_stall),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .o_frame_byte (o_frame_byte),
        .o_frame_end  (o_frame_end)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !w_push)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("queue read while empty");

    a_sync_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end && !i_stall) |=>
            (!o_valid || (o_frame_byte == cmf_pkg::SYNC_BYTE && !o_frame_end)))
        else $error("word after frame end is not a sync word");

endmodule

[tb/tb_crc16_message_framer_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the CRC-16 message framer: directed table, then random frames.
module tb_crc16_message_framer_top;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_WAIT        = 20;
    localparam int RAND_PHASES     = 8;
    localparam int WORDS_PER_PHASE = 19;
    localparam int LONG_FRAME      = 255;
    localparam int LONG_WORDS      = 40;
    localparam int N_DIR           = 32;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum {ROW_CFG, ROW_WORD, ROW_PAUSE} t_row_kind;

    typedef struct {
        logic [cmf_pkg::BYTE_W-1:0] fbyte;
        logic                       fend;
    } t_frame_word;

    // header bytes typed in for a word that opens a frame, sync first
    typedef struct {
        bit          given;
        logic [47:0] hdr;
    } t_hdr_note;

    typedef struct {
        t_row_kind         kind;
        cmf_pkg::t_reg_idx idx;
        logic [15:0]       val;
        bit                given;
        logic [47:0]       hdr;
    } t_dir_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [cmf_pkg::BYTE_W-1:0]   i_payload_byte;
    logic                         o_valid;
    logic                         i_stall;
    logic [cmf_pkg::BYTE_W-1:0]   o_frame_byte;
    logic                         o_frame_end;
    logic                         i_cfg_wr_en;
    logic [cmf_pkg::IDX_W-1:0]    i_cfg_index;
    logic [cmf_pkg::CFG_W-1:0]    i_cfg_wr_data;

    crc16_message_framer_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_payload_byte (i_payload_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_byte   (o_frame_byte),
        .o_frame_end    (o_frame_end),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    // predictor copy of the registers and frame state
    logic [7:0]  cfg_msg_type_first;
    logic [7:0]  cfg_msg_type_second;
    logic [15:0] cfg_sender_id;
    logic [7:0]  cfg_payload_length;
    logic [15:0] crc_acc;
    logic [7:0]  taken_cnt;
    bit          framing;

    t_frame_word frame_words_q[$];
    t_hdr_note   hdr_note_q[$];
    int          mismatches;
    int          quiet_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    t_dir_row dir_rows [N_DIR] = '{
        // reset header: types 00/01, sender 2222, length 13
        '{ROW_WORD,  cmf_pkg::REG_MSG_TYPE_FIRST,  16'h0000, 1'b1, 48'h55_00_01_22_22_0D},
        '{ROW_PAUSE, cmf_pkg::REG_MSG_TYPE_FIRST,  16'h0000, 1'b0, 48'h0},
        // length drops to what is already taken: next word closes the frame
        '{ROW_CFG,   cmf_pkg::REG_PAYLOAD_LENGTH,  16'h0001, 1'b0, 48'h0},
        '{ROW_WORD,  cmf_pkg::REG_MSG_TYPE_FIRST,  16'h00FF, 1'b0, 48'h0},
        '{ROW_PAUSE, cmf_pkg::REG_MSG_TYPE_FIRST,  16'h0000, 1'b0, 48'h0},
        '{ROW_CFG,   cmf_pkg::REG_MSG_TYPE_FIRST,  16'hA5FF, 1'b0, 48'h0},
        '{ROW_CFG,   cmf_pkg::REG_MSG_TYPE_SECOND, 16'h5A00, 1'b0, 48'h0},
        '{ROW_CFG,   cmf_pkg::REG_SENDER_ID,       16'hFFFF, 1'b0, 48'h0},
        // length 0 behaves as 1, upper data bits dropped
        '{ROW_CFG,   cmf_pkg::REG_PAYLOAD_LENGTH,  16'h3C00, 1'b0, 48'h0},
        '{ROW_WORD,  cmf_pkg::REG_MSG_TYPE_FIRST,  16'h00AA, 1'b1, 48'h55_FF_00_FF_FF_01},
        '{ROW_WORD,  cmf_pkg::REG_MSG_TYPE_FIRST,  16'h0055, 1'b1, 48'h55_FF_00_FF_FF_01},
        '{ROW_PAUSE, cmf_pkg::REG_MSG_TYPE_FIRST,  16'h0000, 1'b0, 48'h0},
        '{ROW_CFG,   cmf_pkg::REG_MSG_TYPE_FIRST,  16'h0000, 1'b0, 48'h0},
        '{ROW_CFG,   cmf_pkg::REG_MSG_TYPE_SECOND, 16'h00FF, 1'b0, 48'h0},
        '{ROW_CFG,   cmf_pkg::REG_SENDER_ID,       16'h0000, 1'b0, 48'h0},
        '{ROW_CFG,   cmf_pkg::REG_PAYLOAD_LENGTH,  16'h0002, 1'b0, 48'h0},
        '{ROW_WORD,  cmf_pkg::REG_MSG_TYPE_FIRST,  16'h0000, 1'b1, 48'h55_00_FF_00_00_02},
        '{ROW_WORD,  cmf_pkg::REG_MSG_TYPE_FIRST,  16'h00FF, 1'b0, 48'h0},
        '{ROW_WORD,  cmf_pkg::REG_MSG_TYPE_FIRST,  16'h0001, 1'b1, 48'h55_00_FF_00_00_02},
        '{ROW_WORD,  cmf_pkg::REG_MSG_TYPE_FIRST,  16'h0080, 1'b0, 48'h0},
        '{ROW_PAUSE, cmf_pkg::REG_MSG_TYPE_FIRST,  16'h0000, 1'b0, 48'h0},
        '{ROW_CFG,   cmf_pkg::REG_SENDER_ID,       16'hA55A, 1'b0, 48'h0},
        '{ROW_CFG,   cmf_pkg::REG_PAYLOAD_LENGTH,  16'h0003, 1'b0, 48'h0},
        '{ROW_WORD,  cmf_pkg::REG_MSG_TYPE_FIRST,  16'h007F, 1'b1, 48'h55_00_FF_A5_5A_03},
        '{ROW_WORD,  cmf_pkg::REG_MSG_TYPE_FIRST,  16'h0080, 1'b0, 48'h0},
        '{ROW_PAUSE, cmf_pkg::REG_MSG_TYPE_FIRST,  16'h0000, 1'b0, 48'h0},
        // mid-frame: sent header stays, length grows to 5, next frame takes type 12
        '{ROW_CFG,   cmf_pkg::REG_MSG_TYPE_FIRST,  16'h0012, 1'b0, 48'h0},
        '{ROW_CFG,   cmf_pkg::REG_PAYLOAD_LENGTH,  16'h0005, 1'b0, 48'h0},
        '{ROW_WORD,  cmf_pkg::REG_MSG_TYPE_FIRST,  16'h0001, 1'b0, 48'h0},
        '{ROW_WORD,  cmf_pkg::REG_MSG_TYPE_FIRST,  16'h00FE, 1'b0, 48'h0},
        '{ROW_WORD,  cmf_pkg::REG_MSG_TYPE_FIRST,  16'h0033, 1'b0, 48'h0},
        '{ROW_WORD,  cmf_pkg::REG_MSG_TYPE_FIRST,  16'h0042, 1'b1, 48'h55_12_FF_A5_5A_05}
    };

    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? cmf_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    task automatic push_word(input logic [7:0] b, input logic e, input bit hashed);
        t_frame_word w;
        w.fbyte = b;
        w.fend  = e;
        frame_words_q.push_back(w);
        if (hashed) begin
            crc_acc = crc_next(crc_acc, b);
        end
    endtask

    task automatic frame_payload(input logic [7:0] b, input t_hdr_note note);
        logic [7:0]  len_b;
        logic [47:0] hdr;
        len_b = (cfg_payload_length == 8'd0) ? 8'd1 : cfg_payload_length;
        if (!framing) begin
            crc_acc   = '0;
            taken_cnt = '0;
            hdr = note.given ? note.hdr : {cmf_pkg::SYNC_BYTE, cfg_msg_type_first,
                                           cfg_msg_type_second, cfg_sender_id, len_b};
            push_word(hdr[47:40], 1'b0, 1'b0);
            for (int i = 4; i >= 0; i--) begin
                push_word(hdr[i*8 +: 8], 1'b0, 1'b1);
            end
            framing = 1'b1;
        end
        push_word(b, 1'b0, 1'b1);
        if (taken_cnt != 8'hFF) begin
            taken_cnt = taken_cnt + 8'd1;
        end
        if (taken_cnt >= len_b) begin
            push_word(crc_acc[7:0], 1'b0, 1'b0);
            push_word(crc_acc[15:8], 1'b1, 1'b0);
            crc_acc   = '0;
            taken_cnt = '0;
            framing   = 1'b0;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // prediction and checking on pre-edge values
    always @(posedge i_clk) begin
        t_hdr_note   note;
        t_frame_word want;
        bit          moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            cfg_msg_type_first  = cmf_pkg::MSG_TYPE_FIRST_RST;
            cfg_msg_type_second = cmf_pkg::MSG_TYPE_SECOND_RST;
            cfg_sender_id       = cmf_pkg::SENDER_ID_RST;
            cfg_payload_length  = cmf_pkg::PAYLOAD_LENGTH_RST;
            crc_acc   = '0;
            taken_cnt = '0;
            framing   = 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                moved      = 1'b1;
                note.given = 1'b0;
                note.hdr   = '0;
                if (hdr_note_q.size() != 0) begin
                    note = hdr_note_q.pop_front();
                end
                frame_payload(i_payload_byte, note);
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                if (frame_words_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word: expected none, actual %02h end %0b",
                             $time, o_frame_byte, o_frame_end);
                end else begin
                    want = frame_words_q.pop_front();
                    if (o_frame_byte !== want.fbyte) begin
                        mismatches++;
                        $display("%0t: frame_byte expected %02h actual %02h",
                                 $time, want.fbyte, o_frame_byte);
                    end
                    if (o_frame_end !== want.fend) begin
                        mismatches++;
                        $display("%0t: frame_end expected %0b actual %0b",
                                 $time, want.fend, o_frame_end);
                    end
                end
            end
            if (i_cfg_wr_en) begin
                case (cmf_pkg::t_reg_idx'(i_cfg_index))
                    cmf_pkg::REG_MSG_TYPE_FIRST:  cfg_msg_type_first  = i_cfg_wr_data[7:0];
                    cmf_pkg::REG_MSG_TYPE_SECOND: cfg_msg_type_second = i_cfg_wr_data[7:0];
                    cmf_pkg::REG_SENDER_ID:       cfg_sender_id       = i_cfg_wr_data;
                    cmf_pkg::REG_PAYLOAD_LENGTH:  cfg_payload_length  = i_cfg_wr_data[7:0];
                    default: ;
                endcase
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("crc16_message_framer_top: mismatch");
        $finish;
    end

    task automatic send_word(input logic [7:0] b, input bit given, input logic [47:0] hdr);
        t_hdr_note note;
        note.given = given;
        note.hdr   = hdr;
        i_cfg_wr_en <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        hdr_note_q.push_back(note);
        i_valid        <= 1'b1;
        i_payload_byte <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic cfg_write(input cmf_pkg::t_reg_idx idx, input logic [15:0] data);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= data;
        @(posedge i_clk);
    endtask

    // hold the sender until every framed word is out, then pick the next idling mode
    task automatic settle(input t_idle_mode mode);
        i_valid     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        do @(negedge i_clk); while (frame_words_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 75; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default:       begin send_idle_pct = 30; recv_stall_pct = 30; end
        endcase
        @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] len;
        mismatches     = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_payload_byte <= '0;
        i_stall        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_index    <= cmf_pkg::REG_MSG_TYPE_FIRST;
        i_cfg_wr_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            case (dir_rows[r].kind)
                ROW_CFG:   cfg_write(dir_rows[r].idx, dir_rows[r].val);
                ROW_WORD:  send_word(dir_rows[r].val[7:0], dir_rows[r].given, dir_rows[r].hdr);
                default:   settle(IDLE_NONE);
            endcase
        end

        // random phases; the open frame of one phase usually spans the next config change
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle(t_idle_mode'(ph % 4));
            len = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(1, 9));
            cfg_write(cmf_pkg::REG_MSG_TYPE_FIRST,  16'($urandom));
            cfg_write(cmf_pkg::REG_MSG_TYPE_SECOND, 16'($urandom));
            cfg_write(cmf_pkg::REG_SENDER_ID,       16'($urandom));
            cfg_write(cmf_pkg::REG_PAYLOAD_LENGTH,  {8'($urandom), len});
            repeat (WORDS_PER_PHASE) send_word(8'($urandom), 1'b0, '0);
        end

        // close whatever is open, then open a frame at the longest length and cut it short
        settle(IDLE_NONE);
        cfg_write(cmf_pkg::REG_PAYLOAD_LENGTH, 16'h0001);
        send_word(8'($urandom), 1'b0, '0);
        settle(IDLE_BOTH);
        cfg_write(cmf_pkg::REG_MSG_TYPE_FIRST, 16'($urandom));
        cfg_write(cmf_pkg::REG_SENDER_ID,      16'($urandom));
        cfg_write(cmf_pkg::REG_PAYLOAD_LENGTH, 16'(LONG_FRAME));
        repeat (LONG_WORDS) send_word(8'($urandom), 1'b0, '0);
        settle(IDLE_BOTH);
        cfg_write(cmf_pkg::REG_PAYLOAD_LENGTH, 16'h0001);
        send_word(8'($urandom), 1'b0, '0);

        settle(IDLE_NONE);
        repeat (END_WAIT) @(posedge i_clk);
        if (mismatches == 0 && frame_words_q.size() == 0) begin
            $display("crc16_message_framer_top: match");
        end else begin
            $display("crc16_message_framer_top: mismatch");
        end
        $finish;
    end

endmodule

[crc16_message_framer_top.f]
rtl/cmf_pkg.sv
rtl/cmf_front.sv
rtl/cmf_queue.sv
rtl/cmf_back.sv
rtl/crc16_message_framer_top.sv
tb/tb_crc16_message_framer_top.sv
